@@ hdl/jsud_pkg.sv @@
package jsud_pkg;

  // Byte values of interest in the source text
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHAR_SLASH     = 8'h2f;
  localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
  localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
  localparam logic [7:0] CHAR_LOWER_N   = 8'h6e;
  localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
  localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
  localparam logic [7:0] CHAR_LOWER_U   = 8'h75;

  // UTF-8 encoding constants
  localparam logic [15:0] CODE_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] CODE_TWO_LIMIT = 16'h0800;
  localparam logic [7:0]  LEAD_TWO       = 8'hc0;
  localparam logic [7:0]  LEAD_THREE     = 8'he0;
  localparam logic [7:0]  CONT_MARK      = 8'h80;
  localparam logic [5:0]  CONT_MASK      = 6'h3f;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    EV_BYTE  = 2'd0,
    EV_DONE  = 2'd1,
    EV_ERROR = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    ERR_NONE           = 3'd0,
    ERR_NO_OPEN_QUOTE  = 3'd1,
    ERR_UNTERM_STRING  = 3'd2,
    ERR_UNTERM_ESCAPE  = 3'd3,
    ERR_SHORT_UNICODE  = 3'd4,
    ERR_BAD_HEX        = 3'd5,
    ERR_UNKNOWN_ESCAPE = 3'd6
  } error_e;

  // Parser state, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_STRING = 4'b0010,
    MODE_ESCAPE = 4'b0100,
    MODE_HEX    = 4'b1000
  } mode_e;

  // One command from the parser to the output expander
  typedef struct packed {
    logic [1:0]  count;  // number of results, 1 to 3
    logic [15:0] code;   // byte value or code point
    event_e      ev;
    error_e      err;
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] value;
  } esc_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r.value = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r.value = c[3:0] + 4'd9;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic esc_t escape_decode(input logic [7:0] c);
    esc_t r;
    r.ok = 1'b1;
    case (c)
      CHAR_QUOTE:     r.value = CHAR_QUOTE;
      CHAR_BACKSLASH: r.value = CHAR_BACKSLASH;
      CHAR_SLASH:     r.value = CHAR_SLASH;
      CHAR_LOWER_B:   r.value = 8'h08;
      CHAR_LOWER_F:   r.value = 8'h0c;
      CHAR_LOWER_N:   r.value = 8'h0a;
      CHAR_LOWER_R:   r.value = 8'h0d;
      CHAR_LOWER_T:   r.value = 8'h09;
      default: begin
        r.ok    = 1'b0;
        r.value = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage

@@ hdl/jsud_if.sv @@
interface jsud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_source;

  modport source (output valid, output in_byte, output end_of_source, input ready);
  modport sink (input valid, input in_byte, input end_of_source, output ready);
endinterface

interface jsud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [1:0] event_res;
  logic [2:0] error_code;
  logic       last_of_run;

  modport source (output valid, output byte_out, output event_res, output error_code,
                  output last_of_run, input ready);
  modport sink (input valid, input byte_out, input event_res, input error_code,
                input last_of_run, output ready);
endinterface

@@ hdl/json_string_unescape_decoder_unit.sv @@
// JSON string unescape decoder. Bytes of a quoted JSON string enter on in_i,
// starting with the opening quote; decoded bytes, a done event at the closing
// quote, or an error event leave on out_o, one result per transfer, with
// last_of_run marking the final result caused by an input byte. The input side
// takes one byte per cycle whenever the two-entry command queue between the
// parser and the output expander has room; the output side gives one result
// per cycle while the receiver is ready, and a \u escape that expands to three
// UTF-8 bytes still arrives as six input bytes. Sustained throughput is
// therefore one input byte per cycle while the queue has room and the receiver
// is ready, set by the single parser stage and the one-result-per-cycle output
// register; an accepted byte's first result is registered in the queue and then in the output register.
module json_string_unescape_decoder_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  jsud_in_if.sink           in_i,
  jsud_out_if.source        out_o
);
  import jsud_pkg::*;

  // Commands from the parser into the queue
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;

  // Queue head towards the expander
  logic cmd_valid;
  cmd_t cmd_head;
  logic cmd_pop;

  // The parser classifies each byte and pushes at most one command, which
  // describes every result that byte causes.
  jsud_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .in_byte_i       (in_i.in_byte),
    .end_of_source_i (in_i.end_of_source),
    .cmd_full_i      (cmd_full),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in)
  );

  // A short queue so that a stalled output does not immediately stop input.
  jsud_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_push),
    .push_cmd_i (cmd_in),
    .full_o     (cmd_full),
    .pop_i      (cmd_pop),
    .valid_o    (cmd_valid),
    .head_o     (cmd_head)
  );

  // The expander turns each command into one to three registered results.
  jsud_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd_head),
    .cmd_pop_o     (cmd_pop),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .byte_out_o    (out_o.byte_out),
    .event_res_o   (out_o.event_res),
    .error_code_o  (out_o.error_code),
    .last_of_run_o (out_o.last_of_run)
  );

endmodule

@@ hdl/jsud_front.sv @@
module jsud_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  input  logic            end_of_source_i,
  input  logic            cmd_full_i,
  output logic            cmd_push_o,
  output jsud_pkg::cmd_t  cmd_o
);
  import jsud_pkg::*;

  mode_e       mode_q, mode_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [11:0] acc_q, acc_d;
  logic        accept;
  logic        err_hit;
  error_e      err_val;
  hex_t        hex;
  esc_t        esc;
  logic [15:0] code;

  assign in_ready_o = !cmd_full_i;
  assign accept     = in_valid_i && !cmd_full_i;
  assign hex        = hex_decode(in_byte_i);
  assign esc        = escape_decode(in_byte_i);
  assign code       = {acc_q, hex.value};

  always_comb begin
    mode_d     = mode_q;
    hex_cnt_d  = hex_cnt_q;
    acc_d      = acc_q;
    cmd_push_o = 1'b0;
    err_hit    = 1'b0;
    err_val    = ERR_NONE;
    cmd_o      = '{count: 2'd1, code: 16'h0000, ev: EV_BYTE, err: ERR_NONE};
    if (accept) begin
      if (end_of_source_i) begin
        err_hit = 1'b1;
        case (mode_q)
          MODE_IDLE:   err_val = ERR_NO_OPEN_QUOTE;
          MODE_STRING: err_val = ERR_UNTERM_STRING;
          MODE_ESCAPE: err_val = ERR_UNTERM_ESCAPE;
          default:     err_val = ERR_SHORT_UNICODE;
        endcase
      end else begin
        case (mode_q)
          MODE_IDLE: begin
            if (in_byte_i == CHAR_QUOTE) begin
              mode_d = MODE_STRING;
            end else begin
              err_hit = 1'b1;
              err_val = ERR_NO_OPEN_QUOTE;
            end
          end
          MODE_STRING: begin
            if (in_byte_i == CHAR_QUOTE) begin
              mode_d     = MODE_IDLE;
              cmd_push_o = 1'b1;
              cmd_o.ev   = EV_DONE;
            end else if (in_byte_i == CHAR_BACKSLASH) begin
              mode_d = MODE_ESCAPE;
            end else begin
              cmd_push_o = 1'b1;
              cmd_o.code = {8'h00, in_byte_i};
            end
          end
          MODE_ESCAPE: begin
            if (in_byte_i == CHAR_LOWER_U) begin
              mode_d    = MODE_HEX;
              hex_cnt_d = 2'd0;
              acc_d     = 12'h000;
            end else if (esc.ok) begin
              mode_d     = MODE_STRING;
              cmd_push_o = 1'b1;
              cmd_o.code = {8'h00, esc.value};
            end else begin
              err_hit = 1'b1;
              err_val = ERR_UNKNOWN_ESCAPE;
            end
          end
          MODE_HEX: begin
            if (!hex.ok) begin
              err_hit = 1'b1;
              err_val = ERR_BAD_HEX;
            end else if (hex_cnt_q != 2'd3) begin
              acc_d     = {acc_q[7:0], hex.value};
              hex_cnt_d = hex_cnt_q + 2'd1;
            end else begin
              mode_d     = MODE_STRING;
              hex_cnt_d  = 2'd0;
              acc_d      = 12'h000;
              cmd_push_o = 1'b1;
              cmd_o.code = code;
              if (code < CODE_ONE_LIMIT) begin
                cmd_o.count = 2'd1;
              end else if (code < CODE_TWO_LIMIT) begin
                cmd_o.count = 2'd2;
              end else begin
                cmd_o.count = 2'd3;
              end
            end
          end
          default: mode_d = MODE_IDLE;
        endcase
      end
      if (err_hit) begin
        mode_d     = MODE_IDLE;
        hex_cnt_d  = 2'd0;
        acc_d      = 12'h000;
        cmd_push_o = 1'b1;
        cmd_o      = '{count: 2'd1, code: 16'h0000, ev: EV_ERROR, err: err_val};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      hex_cnt_q <= 2'd0;
      acc_q     <= 12'h000;
    end else begin
      mode_q    <= mode_d;
      hex_cnt_q <= hex_cnt_d;
      acc_q     <= acc_d;
    end
  end

endmodule

@@ hdl/jsud_cmd_fifo.sv @@
module jsud_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  jsud_pkg::cmd_t  push_cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output jsud_pkg::cmd_t  head_o
);
  import jsud_pkg::*;

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hdl/jsud_back.sv @@
module jsud_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  jsud_pkg::cmd_t  cmd_i,
  output logic            cmd_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      byte_out_o,
  output logic [1:0]      event_res_o,
  output logic [2:0]      error_code_o,
  output logic            last_of_run_o
);
  import jsud_pkg::*;

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q, byte_d;
  logic [1:0] event_q;
  logic [2:0] error_q;
  logic       last_q, last_d;
  logic       load;

  assign load      = cmd_valid_i && (!valid_q || out_ready_i);
  assign last_d    = (idx_q == cmd_i.count - 2'd1);
  assign cmd_pop_o = load && last_d;

  // Pick the UTF-8 byte for the current position within the command
  always_comb begin
    byte_d = 8'h00;
    if (cmd_i.ev == EV_BYTE) begin
      case (cmd_i.count)
        2'd2: begin
          if (idx_q == 2'd0) begin
            byte_d = LEAD_TWO | {3'b000, cmd_i.code[10:6]};
          end else begin
            byte_d = CONT_MARK | {2'b00, cmd_i.code[5:0] & CONT_MASK};
          end
        end
        2'd3: begin
          case (idx_q)
            2'd0:    byte_d = LEAD_THREE | {4'h0, cmd_i.code[15:12]};
            2'd1:    byte_d = CONT_MARK | {2'b00, cmd_i.code[11:6] & CONT_MASK};
            default: byte_d = CONT_MARK | {2'b00, cmd_i.code[5:0] & CONT_MASK};
          endcase
        end
        default: byte_d = cmd_i.code[7:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= last_d ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= byte_d;
      event_q <= cmd_i.ev;
      error_q <= cmd_i.err;
      last_q  <= last_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign byte_out_o    = byte_q;
  assign event_res_o   = event_q;
  assign error_code_o  = error_q;
  assign last_of_run_o = last_q;

endmodule

@@ dv/testbench.sv @@
// Self-checking bench for the JSON string unescape decoder.
//
// Source items (a byte, or an end-of-source marker) wait in a queue that the
// control process fills one phase at a time. A clocked driver offers them on
// the input channel. At every accepted transfer the driver runs the bench's
// own decoder, which appends the results that the byte should cause to a
// queue of expected decoded results. A clocked monitor compares every
// accepted output transfer with the oldest entry of that queue.
module testbench;
  import jsud_pkg::*;

  localparam int unsigned HalfPeriod  = 4;
  localparam int unsigned ResetCycles = 8;
  // Length of the long receiver hold-off used to back the block up.
  localparam int unsigned HoldCycles  = 400;
  // Cycles allowed after the last expected result before the verdict.
  localparam int unsigned DrainCycles = 16;
  // This leaves a wide margin over the slowest legal run.
  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned ReportLimit = 10;

  // One item of source text as the driver offers it.
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } source_item_t;

  // One decoded result as the block should give it.
  typedef struct packed {
    logic [7:0] data;
    event_e     ev;
    error_e     err;
    logic       last;
  } decoded_t;

  // How a randomly built string is brought to an end.
  typedef enum int unsigned {
    END_CLOSE,
    END_IN_STRING,
    END_AFTER_BACKSLASH,
    END_IN_HEX,
    END_BAD_HEX,
    END_UNKNOWN_ESC
  } string_end_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  jsud_in_if  in_if ();
  jsud_out_if out_if ();

  json_string_unescape_decoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  source_item_t source_q[$];
  decoded_t     decoded_q[$];
  source_item_t next_item;

  // Idling odds for the current phase, in percent of cycles.
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;

  // The control process raises hold_req for one cycle; the counter below then
  // keeps the receiver from taking results until it has counted down from HoldCycles.
  logic        hold_req;
  int unsigned hold_left;

  int unsigned cycle_count;
  int unsigned bad_results;

  // State of the bench's own decoder.
  mode_e       dec_mode;
  logic [1:0]  hex_count;
  logic [11:0] hex_acc;

  // ---------------------------------------------------------------------------
  // Decoder used for prediction
  // ---------------------------------------------------------------------------

  function automatic void add_result(input logic [7:0] data, input event_e ev,
                                     input error_e err, input logic last);
    decoded_t r;
    r.data = data;
    r.ev   = ev;
    r.err  = err;
    r.last = last;
    decoded_q = {decoded_q, r};
  endfunction

  // Every error is a single result and sends the decoder back to idle with
  // the partial \u value thrown away.
  function automatic void report_error(input error_e err);
    dec_mode  = MODE_IDLE;
    hex_count = '0;
    hex_acc   = '0;
    add_result(8'h00, EV_ERROR, err, 1'b1);
  endfunction

  function automatic int nibble_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic void decode_source_item(input logic [7:0] c, input logic eos);
    logic [15:0] code;
    int          digit;
    if (eos) begin
      // The error depends only on where in the string the source ran out.
      case (dec_mode)
        MODE_IDLE:   report_error(ERR_NO_OPEN_QUOTE);
        MODE_STRING: report_error(ERR_UNTERM_STRING);
        MODE_ESCAPE: report_error(ERR_UNTERM_ESCAPE);
        default:     report_error(ERR_SHORT_UNICODE);
      endcase
    end else begin
      case (dec_mode)
        MODE_IDLE: begin
          if (c == CHAR_QUOTE) dec_mode = MODE_STRING;
          else report_error(ERR_NO_OPEN_QUOTE);
        end
        MODE_STRING: begin
          if (c == CHAR_QUOTE) begin
            dec_mode = MODE_IDLE;
            add_result(8'h00, EV_DONE, ERR_NONE, 1'b1);
          end else if (c == CHAR_BACKSLASH) begin
            dec_mode = MODE_ESCAPE;
          end else begin
            add_result(c, EV_BYTE, ERR_NONE, 1'b1);
          end
        end
        MODE_ESCAPE: begin
          dec_mode = MODE_STRING;
          case (c)
            CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: add_result(c, EV_BYTE, ERR_NONE, 1'b1);
            CHAR_LOWER_B: add_result(8'h08, EV_BYTE, ERR_NONE, 1'b1);
            CHAR_LOWER_F: add_result(8'h0c, EV_BYTE, ERR_NONE, 1'b1);
            CHAR_LOWER_N: add_result(8'h0a, EV_BYTE, ERR_NONE, 1'b1);
            CHAR_LOWER_R: add_result(8'h0d, EV_BYTE, ERR_NONE, 1'b1);
            CHAR_LOWER_T: add_result(8'h09, EV_BYTE, ERR_NONE, 1'b1);
            CHAR_LOWER_U: begin
              dec_mode  = MODE_HEX;
              hex_count = '0;
              hex_acc   = '0;
            end
            default: report_error(ERR_UNKNOWN_ESCAPE);
          endcase
        end
        default: begin
          digit = nibble_value(c);
          if (digit < 0) begin
            // A bad digit is reported at once, wherever it falls.
            report_error(ERR_BAD_HEX);
          end else if (hex_count < 2'd3) begin
            hex_acc   = {hex_acc[7:0], digit[3:0]};
            hex_count = hex_count + 2'd1;
          end else begin
            code      = {hex_acc, digit[3:0]};
            dec_mode  = MODE_STRING;
            hex_count = '0;
            hex_acc   = '0;
            // UTF-8 encoding of the code point; surrogates are not paired.
            if (code < CODE_ONE_LIMIT) begin
              add_result(code[7:0], EV_BYTE, ERR_NONE, 1'b1);
            end else if (code < CODE_TWO_LIMIT) begin
              add_result(LEAD_TWO | {3'b000, code[10:6]}, EV_BYTE, ERR_NONE, 1'b0);
              add_result(CONT_MARK | {2'b00, code[5:0]}, EV_BYTE, ERR_NONE, 1'b1);
            end else begin
              add_result(LEAD_THREE | {4'h0, code[15:12]}, EV_BYTE, ERR_NONE, 1'b0);
              add_result(CONT_MARK | {2'b00, code[11:6]}, EV_BYTE, ERR_NONE, 1'b0);
              add_result(CONT_MARK | {2'b00, code[5:0]}, EV_BYTE, ERR_NONE, 1'b1);
            end
          end
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Source text generation
  // ---------------------------------------------------------------------------

  function automatic void push_src(input logic [7:0] data, input logic eos);
    source_item_t it;
    it.data = data;
    it.eos  = eos;
    source_q = {source_q, it};
  endfunction

  // The byte field carries random junk alongside the end marker.
  function automatic void push_end();
    push_src(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_src(s[i], 1'b0);
  endfunction

  function automatic logic [7:0] escape_letter(input int unsigned idx);
    case (idx)
      0:       escape_letter = CHAR_QUOTE;
      1:       escape_letter = CHAR_BACKSLASH;
      2:       escape_letter = CHAR_SLASH;
      3:       escape_letter = CHAR_LOWER_B;
      4:       escape_letter = CHAR_LOWER_F;
      5:       escape_letter = CHAR_LOWER_N;
      6:       escape_letter = CHAR_LOWER_R;
      default: escape_letter = CHAR_LOWER_T;
    endcase
  endfunction

  // Hex letters come in either case, picked per digit.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    if ($urandom_range(0, 1) != 0) return 8'h41 + {4'h0, v} - 8'd10;
    return 8'h61 + {4'h0, v} - 8'd10;
  endfunction

  // A \u escape with the top n_digits digits of code.
  function automatic void push_unicode(input logic [15:0] code, input int unsigned n_digits);
    push_src(CHAR_BACKSLASH, 1'b0);
    push_src(CHAR_LOWER_U, 1'b0);
    for (int i = 0; i < n_digits; i++) push_src(hex_char(code[15 - 4 * i -: 4]), 1'b0);
  endfunction

  function automatic logic [15:0] random_code();
    case ($urandom_range(0, 2))
      0:       random_code = 16'($urandom_range(16'h0000, 16'h007f));
      1:       random_code = 16'($urandom_range(16'h0080, 16'h07ff));
      default: random_code = 16'($urandom_range(16'h0800, 16'hffff));
    endcase
  endfunction

  // Opening quote, n_chars pieces of random content, then the chosen ending.
  function automatic void add_string(input int unsigned n_chars, input string_end_e ending);
    logic [7:0]  c;
    logic        reject;
    int unsigned kind;
    push_src(CHAR_QUOTE, 1'b0);
    for (int k = 0; k < n_chars; k++) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        do c = 8'($urandom_range(0, 255));
        while (c == CHAR_QUOTE || c == CHAR_BACKSLASH);
        push_src(c, 1'b0);
      end else if (kind < 6) begin
        push_src(CHAR_BACKSLASH, 1'b0);
        push_src(escape_letter($urandom_range(0, 7)), 1'b0);
      end else begin
        push_unicode(random_code(), 4);
      end
    end
    case (ending)
      END_CLOSE:     push_src(CHAR_QUOTE, 1'b0);
      END_IN_STRING: push_end();
      END_AFTER_BACKSLASH: begin
        push_src(CHAR_BACKSLASH, 1'b0);
        push_end();
      end
      END_IN_HEX: begin
        push_unicode(random_code(), $urandom_range(0, 3));
        push_end();
      end
      END_BAD_HEX: begin
        push_unicode(random_code(), $urandom_range(0, 3));
        do c = 8'($urandom_range(0, 255));
        while (nibble_value(c) >= 0);
        push_src(c, 1'b0);
      end
      default: begin
        push_src(CHAR_BACKSLASH, 1'b0);
        do begin
          c      = 8'($urandom_range(0, 255));
          reject = (c == CHAR_LOWER_U);
          for (int j = 0; j < 8; j++) if (c == escape_letter(j)) reject = 1'b1;
        end while (reject);
        push_src(c, 1'b0);
      end
    endcase
  endfunction

  // Stray bytes or end markers between strings; a quote is left out so that
  // the decoder stays idle.
  function automatic void add_noise();
    logic [7:0] c;
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 1) != 0) begin
        push_end();
      end else begin
        do c = 8'($urandom_range(0, 255));
        while (c == CHAR_QUOTE);
        push_src(c, 1'b0);
      end
    end
  endfunction

  // Mostly well-formed strings, so that escapes and \u sequences are decoded
  // in depth; the rest are broken strings and noise.
  function automatic void fill_random(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    start = source_q.size();
    while (source_q.size() - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) add_string($urandom_range(0, 10), END_CLOSE);
      else if (pick < 92) add_string($urandom_range(0, 6), string_end_e'($urandom_range(1, 5)));
      else add_noise();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers one source item per transfer and predicts at acceptance
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid         <= 1'b0;
      in_if.in_byte       <= 8'h00;
      in_if.end_of_source <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        decode_source_item(in_if.in_byte, in_if.end_of_source);
      end
      // A new item may be offered only once the current one has gone.
      if (!in_if.valid || in_if.ready) begin
        if (source_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          next_item = source_q.pop_front();
          in_if.valid         <= 1'b1;
          in_if.in_byte       <= next_item.data;
          in_if.end_of_source <= next_item.eos;
        end else begin
          in_if.valid   <= 1'b0;
          in_if.in_byte <= 8'($urandom_range(0, 255));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver hold-off counter
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every output transfer against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (decoded_q.size() == 0) begin
          if (bad_results < ReportLimit) begin
            $write("cycle %0d: result with nothing expected: ", cycle_count);
            $display("byte %02h event %0d error %0d last %0b",
                     out_if.byte_out, out_if.event_res, out_if.error_code,
                     out_if.last_of_run);
          end
          bad_results <= bad_results + 1;
        end else begin
          if (decoded_q[0].data !== out_if.byte_out ||
              decoded_q[0].ev !== out_if.event_res ||
              decoded_q[0].err !== out_if.error_code ||
              decoded_q[0].last !== out_if.last_of_run) begin
            if (bad_results < ReportLimit) begin
              $write("cycle %0d: expected byte %02h event %0d error %0d last %0b, ",
                     cycle_count, decoded_q[0].data, decoded_q[0].ev, decoded_q[0].err,
                     decoded_q[0].last);
              $display("got byte %02h event %0d error %0d last %0b",
                       out_if.byte_out, out_if.event_res, out_if.error_code,
                       out_if.last_of_run);
            end
            bad_results <= bad_results + 1;
          end
          void'(decoded_q.pop_front());
        end
      end
      out_if.ready <= !(hold_req || hold_left != 0) && $urandom_range(0, 99) >= snk_idle_pct;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               decoded_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Control: reset, then the phases of stimulus
  // ---------------------------------------------------------------------------

  // The sender stays quiet until every expected result has come back.
  task automatic wait_until_drained();
    while (source_q.size() != 0 || in_if.valid || decoded_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
                           input int unsigned n_items);
    @(negedge clk_i);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    fill_random(n_items);
    wait_until_drained();
  endtask

  initial begin
    // Every input and control signal has a known value from time zero on.
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.in_byte       = 8'h00;
    in_if.end_of_source = 1'b0;
    out_if.ready        = 1'b0;
    hold_req            = 1'b0;
    src_idle_pct        = 0;
    snk_idle_pct        = 0;
    cycle_count         = 0;
    bad_results         = 0;
    dec_mode            = MODE_IDLE;
    hex_count           = '0;
    hex_acc             = '0;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. A stray byte and an end marker while idle, then a string
    // with the byte extremes, a simple escape, a three-byte and a two-byte
    // \u code (mixed-case digits) and the closing quote. After that one
    // string for each way a string can break off: an unknown escape, a bad
    // hex digit, the source ending after a backslash, inside \u and inside
    // the string itself.
    push_src("x", 1'b0);
    push_end();
    push_src(CHAR_QUOTE, 1'b0);
    push_src(8'h00, 1'b0);
    push_src(8'hff, 1'b0);
    push_text("\\t\\uFfFf\\u07fF\"");
    push_text("\"\\q");
    push_text("\"\\ug");
    push_text("\"\\");
    push_end();
    push_text("\"\\u");
    push_end();
    push_src(CHAR_QUOTE, 1'b0);
    push_end();
    wait_until_drained();

    // Random part, with each idling pattern in turn.
    run_phase(0, 0, 90);
    run_phase(88, 0, 60);
    run_phase(0, 88, 60);
    run_phase(38, 38, 80);

    // The receiver holds off for a long stretch while the sender keeps
    // offering at full rate, so that the block fills up and stalls its input.
    @(negedge clk_i);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_req     = 1'b1;
    fill_random(30);
    @(negedge clk_i);
    hold_req = 1'b0;
    wait_until_drained();

    run_phase(0, 0, 30);

    // Any result that turns up now has no expectation and is flagged.
    repeat (DrainCycles) @(posedge clk_i);
    if (bad_results == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d bad results", bad_results);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/jsud_pkg.sv
hdl/jsud_if.sv
hdl/jsud_front.sv
hdl/jsud_cmd_fifo.sv
hdl/jsud_back.sv
hdl/json_string_unescape_decoder_unit.sv
dv/testbench.sv
